/* src/sust_pkg.sv */
// Shared types and codes for the sorted unique set table.
// Holds the request/result transaction structs, request and status codes, FSM states.
// No dependencies.
package sust_pkg;

    localparam logic [2:0] REQ_INSERT = 3'd0;
    localparam logic [2:0] REQ_DELETE = 3'd1;
    localparam logic [2:0] REQ_FIND   = 3'd2;
    localparam logic [2:0] REQ_CLEAR  = 3'd3;
    localparam logic [2:0] REQ_PRINT  = 3'd4;
    localparam logic [2:0] REQ_EXIT   = 3'd5;

    localparam logic [3:0] ST_INSERTED = 4'd0;
    localparam logic [3:0] ST_DELETED  = 4'd1;
    localparam logic [3:0] ST_FOUND    = 4'd2;
    localparam logic [3:0] ST_ABSENT   = 4'd3;
    localparam logic [3:0] ST_NONPOS   = 4'd4;
    localparam logic [3:0] ST_DUP      = 4'd5;
    localparam logic [3:0] ST_DELMISS  = 4'd6;
    localparam logic [3:0] ST_CLEARED  = 4'd7;
    localparam logic [3:0] ST_HEADER   = 4'd8;
    localparam logic [3:0] ST_ENTRY    = 4'd9;
    localparam logic [3:0] ST_GOODBYE  = 4'd10;
    localparam logic [3:0] ST_UNKNOWN  = 4'd11;

    // stored entry: 31-bit positive value above a 32-bit stamp
    localparam int ENTRY_W = 63;

    typedef struct packed {
        logic [2:0]         req_type;
        logic signed [31:0] value;
        logic [31:0]        now;
    } t_req;

    typedef struct packed {
        logic [3:0]         status;
        logic signed [31:0] result_value;
        logic [31:0]        stamp;
        logic               last;
    } t_res;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_SCAN,
        S_SCAN_CMP,
        S_INS_RD,
        S_INS_WR,
        S_DEL_RD,
        S_DEL_WR,
        S_PR_RD,
        S_PR_CAP,
        S_EMIT
    } t_state;

endpackage

/* src/sorted_unique_set_table.sv */
// Sorted unique set table: top level, with the entry memory and its sequencer.
// Depends on sust_pkg.
//
// Usage:
//   Request channel (i_in_valid / o_in_stall / i_in) carries one command per
//   transaction: insert, delete, find, delete all, print all, exit.
//   Result channel (o_out_valid / i_out_stall / o_out) returns one result per
//   command, or a header plus one result per entry for print all; the final
//   result of each command has last set.
//   One command is processed at a time; o_in_stall is high while it runs.
//   Entries live in one CAPACITY x 63-bit synchronous memory (registered read).
//   Exit, unknown codes, delete all and a nonpositive operand do not touch
//   the memory; find and duplicate scan entries up to the sorted position;
//   insert and delete scan, then shift the later entries to open or close a
//   slot; print all reads each entry in turn. The memory port (one access per
//   cycle) and the linear position scan set how long a command runs. The
//   result register lets a new command be accepted while the previous
//   result waits; a stalled receiver only holds the sequencer when it has
//   another result to hand over.
//   Reset empties the set at once (entry count cleared); no clearing pass.
module sorted_unique_set_table #(
    parameter int CAPACITY = 32
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  sust_pkg::t_req i_in,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output sust_pkg::t_res o_out
);
    import sust_pkg::*;

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

    logic [ENTRY_W-1:0] mem [CAPACITY];

    t_state             r_state, n_state;
    t_req               r_req, n_req;
    logic [CW-1:0]      r_count, n_count;
    logic [CW-1:0]      r_idx, n_idx;
    logic [CW-1:0]      r_pos, n_pos;
    t_res               r_res, n_res;
    logic               r_out_valid;
    t_res               r_out;
    logic [ENTRY_W-1:0] r_rd_data;

    logic               mem_we, mem_re;
    logic [AW-1:0]      mem_wa, mem_ra;
    logic [ENTRY_W-1:0] mem_wd;
    logic               emit;
    logic               scan_done, scan_match;
    logic               positive, out_free;
    logic [30:0]        v31, rd_val;
    logic [31:0]        rd_stamp;
    logic [CW-1:0]      idx_inc, idx_dec;

    assign v31      = r_req.value[30:0];
    assign positive = (r_req.value != 32'sd0) && !r_req.value[31];
    assign rd_val   = r_rd_data[ENTRY_W-1:32];
    assign rd_stamp = r_rd_data[31:0];
    assign out_free = !r_out_valid || !i_out_stall;
    assign idx_inc  = r_idx + 1'b1;
    assign idx_dec  = r_idx - 1'b1;

    always_comb begin
        n_state    = r_state;
        n_req      = r_req;
        n_count    = r_count;
        n_idx      = r_idx;
        n_pos      = r_pos;
        n_res      = r_res;
        mem_we     = 1'b0;
        mem_wa     = '0;
        mem_wd     = '0;
        mem_re     = 1'b0;
        mem_ra     = '0;
        emit       = 1'b0;
        scan_done  = 1'b0;
        scan_match = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_req   = i_in;
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                n_idx              = '0;
                n_state            = S_EMIT;
                n_res.status       = ST_UNKNOWN;
                n_res.result_value = 32'sd0;
                n_res.stamp        = 32'd0;
                n_res.last         = 1'b1;
                case (r_req.req_type)
                    REQ_INSERT, REQ_DELETE, REQ_FIND: begin
                        n_res.result_value = r_req.value;
                        if (positive) begin
                            n_state = S_SCAN;
                        end else if (r_req.req_type == REQ_INSERT) begin
                            n_res.status = ST_NONPOS;
                        end else if (r_req.req_type == REQ_DELETE) begin
                            n_res.status = ST_DELMISS;
                        end else begin
                            n_res.status = ST_ABSENT;
                        end
                    end
                    REQ_CLEAR: begin
                        n_count      = '0;
                        n_res.status = ST_CLEARED;
                    end
                    REQ_PRINT: begin
                        n_res.status = ST_HEADER;
                        n_res.last   = (r_count == '0);
                    end
                    REQ_EXIT: begin
                        n_res.status = ST_GOODBYE;
                    end
                    default: begin
                        n_res.status = ST_UNKNOWN;
                    end
                endcase
            end
            S_SCAN: begin
                if (r_idx == r_count) begin
                    scan_done = 1'b1;
                end else begin
                    mem_re  = 1'b1;
                    mem_ra  = r_idx[AW-1:0];
                    n_state = S_SCAN_CMP;
                end
            end
            S_SCAN_CMP: begin
                if (rd_val < v31) begin
                    n_idx   = idx_inc;
                    n_state = S_SCAN;
                end else begin
                    scan_done  = 1'b1;
                    scan_match = (rd_val == v31);
                end
            end
            S_INS_RD: begin
                if (r_idx == r_pos) begin
                    mem_we             = 1'b1;
                    mem_wa             = r_pos[AW-1:0];
                    mem_wd             = {v31, r_req.now};
                    n_count            = r_count + 1'b1;
                    n_res.status       = ST_INSERTED;
                    n_res.result_value = r_req.value;
                    n_res.stamp        = r_req.now;
                    n_res.last         = 1'b1;
                    n_state            = S_EMIT;
                end else begin
                    mem_re  = 1'b1;
                    mem_ra  = idx_dec[AW-1:0];
                    n_state = S_INS_WR;
                end
            end
            S_INS_WR: begin
                // shift one entry up toward the free slot
                mem_we  = 1'b1;
                mem_wa  = r_idx[AW-1:0];
                mem_wd  = r_rd_data;
                n_idx   = idx_dec;
                n_state = S_INS_RD;
            end
            S_DEL_RD: begin
                if (idx_inc >= r_count) begin
                    n_count            = r_count - 1'b1;
                    n_res.status       = ST_DELETED;
                    n_res.result_value = r_req.value;
                    n_res.stamp        = 32'd0;
                    n_res.last         = 1'b1;
                    n_state            = S_EMIT;
                end else begin
                    mem_re  = 1'b1;
                    mem_ra  = idx_inc[AW-1:0];
                    n_state = S_DEL_WR;
                end
            end
            S_DEL_WR: begin
                // close the gap left by the deleted entry
                mem_we  = 1'b1;
                mem_wa  = r_idx[AW-1:0];
                mem_wd  = r_rd_data;
                n_idx   = idx_inc;
                n_state = S_DEL_RD;
            end
            S_PR_RD: begin
                mem_re  = 1'b1;
                mem_ra  = r_idx[AW-1:0];
                n_state = S_PR_CAP;
            end
            S_PR_CAP: begin
                n_res.status       = ST_ENTRY;
                n_res.result_value = {1'b0, rd_val};
                n_res.stamp        = rd_stamp;
                n_res.last         = (idx_inc == r_count);
                n_idx              = idx_inc;
                n_state            = S_EMIT;
            end
            S_EMIT: begin
                if (out_free) begin
                    emit    = 1'b1;
                    n_state = r_res.last ? S_IDLE : S_PR_RD;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // position found: r_idx is the first entry not below the operand
        if (scan_done) begin
            n_pos              = r_idx;
            n_state            = S_EMIT;
            n_res.result_value = r_req.value;
            n_res.stamp        = 32'd0;
            n_res.last         = 1'b1;
            case (r_req.req_type)
                REQ_INSERT: begin
                    if (scan_match) begin
                        n_res.status = ST_DUP;
                    end else if (r_count >= CW'(CAPACITY)) begin
                        n_res.status = ST_UNKNOWN;
                    end else begin
                        n_idx   = r_count;
                        n_state = S_INS_RD;
                    end
                end
                REQ_DELETE: begin
                    if (scan_match) begin
                        n_state = S_DEL_RD;
                    end else begin
                        n_res.status = ST_DELMISS;
                    end
                end
                default: begin
                    n_res.status = scan_match ? ST_FOUND : ST_ABSENT;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        if (mem_re) begin
            r_rd_data <= mem[mem_ra];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_req <= n_req;
        r_idx <= n_idx;
        r_pos <= n_pos;
        r_res <= n_res;
        if (emit) begin
            r_out <= r_res;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("entry count above capacity");

    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit |-> (!r_out_valid || !i_out_stall))
        else $error("result overwritten while stalled");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("second transaction taken while busy");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$stable(r_count) |-> (r_count == '0 || r_count == $past(r_count) + 1'b1
                               || r_count == $past(r_count) - 1'b1))
        else $error("entry count jumped");

endmodule

/* sim/sorted_unique_set_table_tb.sv */
// Self-checking testbench for the sorted unique set table.
// A shadow copy of the set predicts the results not written in the script table; depends on sust_pkg and the top level.
`timescale 1ns / 1ps

module sorted_unique_set_table_tb;
    import sust_pkg::*;

    localparam int CAP          = 32;
    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int DRAIN_CYCLES = 150;
    localparam int RANDOM_ITEMS = 110;
    localparam int CALM_ITEMS   = 30;

    // request codes the block does not know
    localparam logic [2:0] REQ_UNKNOWN_6 = 3'd6;
    localparam logic [2:0] REQ_UNKNOWN_7 = 3'd7;

    typedef struct packed {
        t_req req;
        bit   typed;
        t_res want;
    } t_row;

    logic i_clk       = 1'b0;
    logic i_rst_n     = 1'b0;
    logic i_in_valid  = 1'b0;
    logic i_out_stall = 1'b0;
    t_req i_in        = '0;
    logic o_in_stall;
    logic o_out_valid;
    t_res o_out;

    // shadow copy of the stored set
    logic [30:0] shadow_vals[CAP];
    logic [31:0] shadow_stamps[CAP];
    int          shadow_count = 0;

    t_res set_replies[$];    // results still owed by the block, oldest first
    t_res fresh_replies[$];  // results of the request just applied to the shadow set
    t_row script[$];

    int fail_count   = 0;
    int cycle_count  = 0;
    int stall_run    = 0;
    bit stall_enable = 1'b1;
    bit idle_enable  = 1'b1;
    t_res head_reply;

    sorted_unique_set_table #(
        .CAPACITY(CAP)
    ) u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in       (i_in),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out      (o_out)
    );

    always #6 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d results outstanding", $time, set_replies.size());
            $display("Simulation FAILED");
            $finish;
        end
    end

    // receiver stalls in random bursts, each burst stalled or free at random
    always @(posedge i_clk) begin
        if (stall_run == 0) begin
            stall_run = $urandom_range(15, 0);
            i_out_stall <= stall_enable && ($urandom_range(1, 0) == 1);
        end else begin
            stall_run = stall_run - 1;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (set_replies.size() == 0) begin
                $display("%0t: result with none expected: status=%0d value=%h stamp=%h last=%b",
                         $time, o_out.status, o_out.result_value, o_out.stamp, o_out.last);
                fail_count++;
            end else begin
                head_reply = set_replies.pop_front();
                if (o_out.status !== head_reply.status ||
                    o_out.result_value !== head_reply.result_value ||
                    o_out.stamp !== head_reply.stamp || o_out.last !== head_reply.last) begin
                    $display("%0t: mismatch: expected status=%0d value=%h stamp=%h last=%b, ",
                             $time, head_reply.status, head_reply.result_value,
                             head_reply.stamp, head_reply.last,
                             "actual status=%0d value=%h stamp=%h last=%b",
                             o_out.status, o_out.result_value, o_out.stamp, o_out.last);
                    fail_count++;
                end
            end
        end
    end

    // Applies one request to the shadow set and leaves its results in fresh_replies.
    task automatic apply_set_request(input t_req r);
        logic [31:0] raw;
        bit          positive;
        bit          hit;
        int          pos;
        int          i;
        t_res        rep;
        raw = r.value;
        positive = (raw != 32'd0) && !raw[31];
        pos = 0;
        if (positive) begin
            while (pos < shadow_count && {1'b0, shadow_vals[pos]} < raw) pos++;
        end
        hit = positive && pos < shadow_count && {1'b0, shadow_vals[pos]} == raw;
        fresh_replies.delete();
        rep = '0;
        rep.last = 1'b1;
        rep.result_value = r.value;
        case (r.req_type)
            REQ_INSERT: begin
                if (!positive) begin
                    rep.status = ST_NONPOS;
                end else if (hit) begin
                    rep.status = ST_DUP;
                end else if (shadow_count >= CAP) begin
                    rep.status = ST_UNKNOWN;
                end else begin
                    for (i = shadow_count; i > pos; i--) begin
                        shadow_vals[i]   = shadow_vals[i - 1];
                        shadow_stamps[i] = shadow_stamps[i - 1];
                    end
                    shadow_vals[pos]   = raw[30:0];
                    shadow_stamps[pos] = r.now;
                    shadow_count++;
                    rep.status = ST_INSERTED;
                    rep.stamp  = r.now;
                end
            end
            REQ_DELETE: begin
                if (hit) begin
                    for (i = pos; i + 1 < shadow_count; i++) begin
                        shadow_vals[i]   = shadow_vals[i + 1];
                        shadow_stamps[i] = shadow_stamps[i + 1];
                    end
                    shadow_count--;
                    rep.status = ST_DELETED;
                end else begin
                    rep.status = ST_DELMISS;
                end
            end
            REQ_FIND: begin
                rep.status = hit ? ST_FOUND : ST_ABSENT;
            end
            REQ_CLEAR: begin
                shadow_count = 0;
                rep.status = ST_CLEARED;
                rep.result_value = '0;
            end
            REQ_PRINT: begin
                rep.status = ST_HEADER;
                rep.result_value = '0;
                rep.last = (shadow_count == 0);
            end
            REQ_EXIT: begin
                rep.status = ST_GOODBYE;
                rep.result_value = '0;
            end
            default: begin
                rep.status = ST_UNKNOWN;
                rep.result_value = '0;
            end
        endcase
        fresh_replies.push_back(rep);
        if (r.req_type == REQ_PRINT) begin
            for (i = 0; i < shadow_count; i++) begin
                rep.status = ST_ENTRY;
                rep.result_value = {1'b0, shadow_vals[i]};
                rep.stamp = shadow_stamps[i];
                rep.last = (i == shadow_count - 1);
                fresh_replies.push_back(rep);
            end
        end
    endtask

    // Presents one request, optionally after an idle burst, and waits for the transaction.
    // A typed row replaces the predicted result with the one written in the table.
    task automatic send_request(input t_req r, input bit typed, input t_res want);
        if (idle_enable && $urandom_range(99, 0) < 30) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(16, 1)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in <= r;
        do @(posedge i_clk); while (o_in_stall);
        apply_set_request(r);
        if (typed) begin
            set_replies.push_back(want);
        end else begin
            foreach (fresh_replies[k]) set_replies.push_back(fresh_replies[k]);
        end
    endtask

    task automatic send_plain(input logic [2:0] op, input logic [31:0] val,
                              input logic [31:0] tnow);
        t_req r;
        r.req_type = op;
        r.value = val;
        r.now = tnow;
        send_request(r, 1'b0, '0);
    endtask

    task automatic add_row(input logic [2:0] op, input logic [31:0] val, input logic [31:0] tnow,
                           input bit typed, input logic [3:0] st, input logic [31:0] rv,
                           input logic [31:0] rs);
        t_row row;
        row.req.req_type = op;
        row.req.value = val;
        row.req.now = tnow;
        row.typed = typed;
        row.want.status = st;
        row.want.result_value = rv;
        row.want.stamp = rs;
        row.want.last = 1'b1;
        script.push_back(row);
    endtask

    function automatic logic [31:0] pick_value();
        case ($urandom_range(9, 0))
            0:       return $urandom;
            1:       return ($urandom_range(1, 0) == 1) ? 32'd0 : {1'b1, 31'($urandom)};
            2:       return 32'h7FFF_FFFF - $urandom_range(3, 0);
            default: return $urandom_range(48, 1);
        endcase
    endfunction

    initial begin
        int          n;
        int          pick;
        t_row        row;
        logic [2:0]  op;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        add_row(REQ_PRINT,     32'd0,          32'd0,          1, ST_HEADER,   32'd0, 32'd0);
        add_row(REQ_FIND,      32'd5,          32'd7,          1, ST_ABSENT,   32'd5, 32'd0);
        add_row(REQ_INSERT,    32'd0,          32'd9,          1, ST_NONPOS,   32'd0, 32'd0);
        add_row(REQ_INSERT,    32'hFFFF_FFFF,  32'd9,          1, ST_NONPOS,
                32'hFFFF_FFFF, 32'd0);
        add_row(REQ_INSERT,    32'h8000_0000,  32'd9,          1, ST_NONPOS,
                32'h8000_0000, 32'd0);
        add_row(REQ_INSERT,    32'h7FFF_FFFF,  32'hFFFF_FFFF,  1, ST_INSERTED,
                32'h7FFF_FFFF, 32'hFFFF_FFFF);
        add_row(REQ_INSERT,    32'd1,          32'd0,          1, ST_INSERTED, 32'd1, 32'd0);
        add_row(REQ_INSERT,    32'd1000,       32'h0001_E240,  0, '0, '0, '0);
        add_row(REQ_INSERT,    32'd1000,       32'd77,         0, '0, '0, '0);
        add_row(REQ_FIND,      32'd1000,       32'd0,          0, '0, '0, '0);
        add_row(REQ_FIND,      32'd1001,       32'd0,          0, '0, '0, '0);
        add_row(REQ_FIND,      32'hFFFF_FFFB,  32'd0,          1, ST_ABSENT,
                32'hFFFF_FFFB, 32'd0);
        add_row(REQ_PRINT,     32'd0,          32'd0,          0, '0, '0, '0);
        add_row(REQ_DELETE,    32'd1000,       32'd0,          0, '0, '0, '0);
        add_row(REQ_DELETE,    32'd1000,       32'd0,          0, '0, '0, '0);
        add_row(REQ_DELETE,    32'd0,          32'd0,          1, ST_DELMISS,  32'd0, 32'd0);
        add_row(REQ_DELETE,    32'h8000_0000,  32'd0,          1, ST_DELMISS,
                32'h8000_0000, 32'd0);
        add_row(REQ_DELETE,    32'h7FFF_FFFF,  32'd0,          0, '0, '0, '0);
        add_row(REQ_EXIT,      32'd42,         32'd0,          1, ST_GOODBYE,  32'd0, 32'd0);
        add_row(REQ_UNKNOWN_6, 32'd3,          32'd0,          1, ST_UNKNOWN,  32'd0, 32'd0);
        add_row(REQ_UNKNOWN_7, 32'hFFFF_FFFF,  32'hFFFF_FFFF,  1, ST_UNKNOWN,  32'd0, 32'd0);
        add_row(REQ_PRINT,     32'd0,          32'd0,          0, '0, '0, '0);
        add_row(REQ_CLEAR,     32'd9,          32'd0,          1, ST_CLEARED,  32'd0, 32'd0);
        add_row(REQ_PRINT,     32'd0,          32'd0,          1, ST_HEADER,   32'd0, 32'd0);

        for (n = 0; n < script.size(); n++) begin
            row = script[n];
            send_request(row.req, row.typed, row.want);
        end

        // fill in descending order so every insert shifts the whole set, then hit the full case
        for (n = 0; n < CAP; n++) begin
            send_plain(REQ_INSERT, (CAP - n) * 1000 + $urandom_range(999, 0), $urandom);
        end
        send_plain(REQ_INSERT, 32'd7, $urandom);
        send_plain(REQ_INSERT, {1'b0, shadow_vals[CAP / 2]}, $urandom);
        send_plain(REQ_INSERT, 32'd0, $urandom);
        send_plain(REQ_PRINT, $urandom, $urandom);

        // hold off until the block has handed over everything
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (set_replies.size() != 0);

        send_plain(REQ_CLEAR, $urandom, $urandom);
        for (n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == RANDOM_ITEMS - CALM_ITEMS) begin
                idle_enable = 1'b0;
                stall_enable = 1'b0;
            end
            pick = $urandom_range(99, 0);
            if (pick < 34) op = REQ_INSERT;
            else if (pick < 54) op = REQ_DELETE;
            else if (pick < 72) op = REQ_FIND;
            else if (pick < 80) op = REQ_PRINT;
            else if (pick < 83) op = REQ_CLEAR;
            else if (pick < 86) op = REQ_EXIT;
            else if (pick < 92) op = ($urandom_range(1, 0) == 1) ? REQ_UNKNOWN_6 : REQ_UNKNOWN_7;
            else op = 3'($urandom);
            send_plain(op, (pick < 92) ? pick_value() : $urandom, $urandom);
        end

        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (set_replies.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
